// ===== rtl/afct_pkg.sv =====
package afct_pkg;

  localparam int PLANE_COUNT  = 6;
  localparam int CORNER_COUNT = 8;
  localparam int PLANE_AW     = 3;
  localparam int CORNER_AW    = 3;
  localparam int SLOT_W       = 3;
  localparam int FIELD_W      = 32;
  localparam int EXT_W        = 31;
  localparam int FRAC_SPLIT   = 17;
  localparam int AXES         = 3;

  localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
  localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
  localparam logic [1:0] OP_TEST_BOX    = 2'd2;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_PLANE = 2'd1;
  localparam logic [1:0] CAUSE_FACE  = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic [SLOT_W-1:0]        slot;
    logic signed [FIELD_W-1:0] value_x;
    logic signed [FIELD_W-1:0] value_y;
    logic signed [FIELD_W-1:0] value_z;
    logic signed [FIELD_W-1:0] value_w;
    logic [EXT_W-1:0]         extent_x;
    logic [EXT_W-1:0]         extent_y;
    logic [EXT_W-1:0]         extent_z;
  } afct_in_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] cull_cause;
  } afct_out_t;

endpackage

// ===== rtl/afct_ram.sv =====
module afct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/aabb_frustum_cull_test.sv =====
// Sequence: a test runs PMUL and PACC for each plane, then CCMP for each frustum corner,
//   then FIN; a plane that culls the box sends it straight to FIN, and a result still
//   held in the output register delays the hand-over.
// Throughput: one load per cycle while idle; a test waits for the last result's hand-over and
//   is paced by the single shared multiplier (3 products/plane), one-row-per-cycle corner RAM.
// Reset: rst_n synchronous, active low; clears sequencer and result valid, not the RAMs.
module aabb_frustum_cull_test import afct_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  afct_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output afct_out_t out_data
);

  // Coordinates are the low VAL_W bits of each field, signed.
  localparam int VAL_W  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  // Box min/max at doubled scale: 2*centre +/- full extent.
  localparam int PT_W   = ((VAL_W + 1 > EXT_W + 1) ? VAL_W + 1 : EXT_W + 1) + 1;
  localparam int PROD_W = VAL_W + PT_W;
  // Three products plus the shifted constant term.
  localparam int ACC_W  = PROD_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PACC,
    ST_CCMP,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Plane rows hold {d, c, b, a}; corner rows hold {z, y, x}.
  logic                      plane_we;
  logic [4*VAL_W-1:0]        plane_wdata;
  logic [PLANE_AW-1:0]       plane_raddr;
  logic [4*VAL_W-1:0]        plane_row;
  logic                      corner_we;
  logic [3*VAL_W-1:0]        corner_wdata;
  logic [CORNER_AW-1:0]      corner_raddr;
  logic [3*VAL_W-1:0]        corner_row;

  logic [PLANE_AW-1:0]       p_r, p_nxt;
  logic [CORNER_AW-1:0]      c_r, c_nxt;
  logic [1:0]                k_r, k_nxt;
  logic signed [PT_W-1:0]    mn_r [AXES];
  logic signed [PT_W-1:0]    mn_nxt [AXES];
  logic signed [PT_W-1:0]    mx_r [AXES];
  logic signed [PT_W-1:0]    mx_nxt [AXES];
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [AXES-1:0]           above_r, above_nxt;
  logic [AXES-1:0]           below_r, below_nxt;
  logic [1:0]                cause_r, cause_nxt;
  logic                      out_valid_r, out_valid_nxt;
  afct_out_t                 out_data_r, out_data_nxt;

  logic                      in_fire;
  logic [VAL_W-1:0]          ctr [AXES];
  logic [EXT_W-1:0]          ext [AXES];
  logic signed [VAL_W-1:0]   coef_sel;
  logic signed [VAL_W-1:0]   d_term;
  logic signed [PT_W-1:0]    pv_sel;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [PT_W-1:0]    v2 [AXES];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctr[0] = in_data.value_x[VAL_W-1:0];
  assign ctr[1] = in_data.value_y[VAL_W-1:0];
  assign ctr[2] = in_data.value_z[VAL_W-1:0];
  assign ext[0] = in_data.extent_x;
  assign ext[1] = in_data.extent_y;
  assign ext[2] = in_data.extent_z;

  // Write stores straight from the input; a plane slot past the last plane is dropped.
  assign plane_we     = in_fire && (in_data.operation == OP_LOAD_PLANE) &&
                        (in_data.slot < SLOT_W'(PLANE_COUNT));
  assign plane_wdata  = {in_data.value_w[VAL_W-1:0], in_data.value_z[VAL_W-1:0],
                         in_data.value_y[VAL_W-1:0], in_data.value_x[VAL_W-1:0]};
  assign corner_we    = in_fire && (in_data.operation == OP_LOAD_CORNER);
  assign corner_wdata = {in_data.value_z[VAL_W-1:0], in_data.value_y[VAL_W-1:0],
                         in_data.value_x[VAL_W-1:0]};

  // Present the next row's address ahead of entry so registered read data is ready on entry.
  always_comb begin
    case (state_r)
      ST_IDLE: plane_raddr = '0;
      ST_PACC: plane_raddr = PLANE_AW'(p_r + 1'b1);
      default: plane_raddr = p_r;
    endcase
    case (state_r)
      ST_IDLE: corner_raddr = '0;
      ST_CCMP: corner_raddr = CORNER_AW'(c_r + 1'b1);
      default: corner_raddr = c_r;
    endcase
  end

  afct_ram #(
    .WIDTH (4*VAL_W),
    .DEPTH (PLANE_COUNT)
  ) u_plane_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (in_data.slot),
    .wdata (plane_wdata),
    .raddr (plane_raddr),
    .rdata (plane_row)
  );

  afct_ram #(
    .WIDTH (3*VAL_W),
    .DEPTH (CORNER_COUNT)
  ) u_corner_ram (
    .clk   (clk),
    .we    (corner_we),
    .waddr (in_data.slot),
    .wdata (corner_wdata),
    .raddr (corner_raddr),
    .rdata (corner_row)
  );

  // Positive vertex: the box corner with the largest dot product for this plane.
  // Take max along an axis with a non-negative coefficient, min otherwise.
  assign coef_sel = plane_row[k_r*VAL_W +: VAL_W];
  assign d_term   = plane_row[3*VAL_W +: VAL_W];
  assign pv_sel   = coef_sel[VAL_W-1] ? mn_r[k_r] : mx_r[k_r];
  assign acc_sum  = acc_r + ACC_W'(prod_r);

  // Frustum corner coordinates at doubled scale, matching min/max.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      v2[i] = {{(PT_W-VAL_W-1){corner_row[i*VAL_W + VAL_W-1]}},
               corner_row[i*VAL_W +: VAL_W], 1'b0};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    cause_nxt     = cause_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.operation == OP_TEST_BOX)) begin
          for (int i = 0; i < AXES; i++) begin
            mn_nxt[i] = $signed({{(PT_W-VAL_W-1){ctr[i][VAL_W-1]}}, ctr[i], 1'b0}) -
                        $signed({{(PT_W-EXT_W){1'b0}}, ext[i]});
            mx_nxt[i] = $signed({{(PT_W-VAL_W-1){ctr[i][VAL_W-1]}}, ctr[i], 1'b0}) +
                        $signed({{(PT_W-EXT_W){1'b0}}, ext[i]});
          end
          p_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          above_nxt = '1;
          below_nxt = '1;
          state_nxt = ST_PMUL;
        end
      end
      ST_PMUL: begin
        // One product per cycle; the first loads the shifted constant term, later ones fold the previous product in.
        prod_nxt = PROD_W'(coef_sel) * PROD_W'(pv_sel);
        if (k_r == 2'd0) begin
          acc_nxt = {{(ACC_W-VAL_W-FRAC_SPLIT){d_term[VAL_W-1]}}, d_term,
                     {FRAC_SPLIT{1'b0}}};
        end else begin
          acc_nxt = acc_sum;
        end
        if (k_r == 2'(AXES-1)) begin
          state_nxt = ST_PACC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_PACC: begin
        k_nxt = '0;
        if (acc_sum[ACC_W-1]) begin
          // Positive vertex below the plane: every box corner is outside.
          cause_nxt = CAUSE_PLANE;
          state_nxt = ST_FIN;
        end else if (p_r == PLANE_AW'(PLANE_COUNT-1)) begin
          state_nxt = ST_CCMP;
        end else begin
          p_nxt     = PLANE_AW'(p_r + 1'b1);
          state_nxt = ST_PMUL;
        end
      end
      ST_CCMP: begin
        for (int i = 0; i < AXES; i++) begin
          above_nxt[i] = above_r[i] && (v2[i] > mx_r[i]);
          below_nxt[i] = below_r[i] && (v2[i] < mn_r[i]);
        end
        c_nxt = CORNER_AW'(c_r + 1'b1);
        if (c_r == CORNER_AW'(CORNER_COUNT-1)) begin
          cause_nxt = |(above_nxt | below_nxt) ? CAUSE_FACE : CAUSE_NONE;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold here until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.visible    = (cause_r == CAUSE_NONE);
          out_data_nxt.cull_cause = cause_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      cause_r     <= CAUSE_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p_r         <= p_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      cause_r     <= cause_nxt;
    end
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    above_r    <= above_nxt;
    below_r    <= below_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sim/tb_aabb_frustum_cull_test.sv =====
module tb_aabb_frustum_cull_test;
  import afct_pkg::*;

  // Encoding that the block drops without a trace.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int Q_ONE        = 65536;          // 1.0 in Q16.16
  localparam int S32_MIN      = -2147483647 - 1;
  localparam int S32_MAX      = 2147483647;
  localparam int EXT_MAX      = 2147483647;     // all 31 extent bits set
  localparam int BOX_CORNERS  = 8;
  localparam int ITEM_TARGET  = 900;
  localparam int DRAIN_CYCLES = 40;             // longer than a full test's latency

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  afct_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  afct_out_t out_data;

  aabb_frustum_cull_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of what the block holds: plane (a, b, c, d) and corner (x, y, z).
  logic signed [FIELD_W-1:0] plane_coef [PLANE_COUNT][4];
  logic signed [FIELD_W-1:0] corner_pos [CORNER_COUNT][AXES];

  // Verdicts still owed by the block, oldest first.
  afct_out_t cull_expect_q [$];

  int  fault_count   = 0;
  int  items_sent    = 0;   // transactions that load or test; dropped ones are not counted
  int  loads_sent    = 0;
  int  dropped_sent  = 0;
  int  tests_sent    = 0;
  int  seen_visible  = 0;
  int  seen_plane    = 0;
  int  seen_face     = 0;
  int  pending_gap   = 0;   // idle cycles before the next input transaction
  int  hold_left     = 0;   // cycles the result side still stalls
  logic calm         = 1'b0;  // when set, neither side idles

  // Exact verdict for one box: bounds kept at doubled scale so the halved
  // size stays integral, plane sums carried in 128 bits so nothing overflows.
  function automatic afct_out_t predict_cull(afct_in_t item);
    longint box_lo [AXES];
    longint box_hi [AXES];
    longint centre2;
    longint corner2;
    logic [EXT_W-1:0] size;
    logic signed [127:0] acc;
    logic signed [127:0] coef_w;
    logic signed [127:0] pos_w;
    logic all_out;
    logic above;
    logic below;
    logic [1:0] cause;
    afct_out_t res;
    int i;
    int p;
    int k;
    for (i = 0; i < AXES; i++) begin
      case (i)
        0: begin
          centre2 = 2 * longint'(item.value_x);
          size = item.extent_x;
        end
        1: begin
          centre2 = 2 * longint'(item.value_y);
          size = item.extent_y;
        end
        default: begin
          centre2 = 2 * longint'(item.value_z);
          size = item.extent_z;
        end
      endcase
      box_lo[i] = centre2 - longint'(size);
      box_hi[i] = centre2 + longint'(size);
    end
    cause = CAUSE_NONE;
    // Plane test first: a box wholly on the negative side of any plane goes.
    // A zero sum counts as inside.
    for (p = 0; p < PLANE_COUNT && cause == CAUSE_NONE; p++) begin
      all_out = 1'b1;
      for (k = 0; k < BOX_CORNERS; k++) begin
        acc = plane_coef[p][3];
        acc = acc <<< FRAC_SPLIT;
        for (i = 0; i < AXES; i++) begin
          coef_w = plane_coef[p][i];
          pos_w = ((k >> i) & 1) ? box_hi[i] : box_lo[i];
          acc = acc + coef_w * pos_w;
        end
        if (!acc[127]) all_out = 1'b0;
      end
      if (all_out) cause = CAUSE_PLANE;
    end
    // Then the face test: every frustum corner strictly past one box face.
    for (i = 0; i < AXES && cause == CAUSE_NONE; i++) begin
      above = 1'b1;
      below = 1'b1;
      for (k = 0; k < CORNER_COUNT; k++) begin
        corner2 = 2 * longint'(corner_pos[k][i]);
        if (!(corner2 > box_hi[i])) above = 1'b0;
        if (!(corner2 < box_lo[i])) below = 1'b0;
      end
      if (above || below) cause = CAUSE_FACE;
    end
    res.visible = (cause == CAUSE_NONE);
    res.cull_cause = cause;
    return res;
  endfunction

  // Apply one accepted transaction to the shadow state and queue its verdict.
  task automatic record_transaction(input afct_in_t item);
    case (item.operation)
      OP_LOAD_PLANE: begin
        if (item.slot < PLANE_COUNT) begin
          plane_coef[item.slot][0] = item.value_x;
          plane_coef[item.slot][1] = item.value_y;
          plane_coef[item.slot][2] = item.value_z;
          plane_coef[item.slot][3] = item.value_w;
          loads_sent++;
          items_sent++;
        end else begin
          dropped_sent++;
        end
      end
      OP_LOAD_CORNER: begin
        corner_pos[item.slot][0] = item.value_x;
        corner_pos[item.slot][1] = item.value_y;
        corner_pos[item.slot][2] = item.value_z;
        loads_sent++;
        items_sent++;
      end
      OP_TEST_BOX: begin
        cull_expect_q.push_back(predict_cull(item));
        tests_sent++;
        items_sent++;
      end
      default: dropped_sent++;
    endcase
  endtask

  // Present one transaction and hold it until accepted. The gap before the
  // following one is drawn here so valid only drops when a gap follows.
  task automatic send_item(input afct_in_t item);
    repeat (pending_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_transaction(item);
    pending_gap = calm ? 0 : $urandom_range(0, 3);
    if (pending_gap > 0) in_valid <= 1'b0;
  endtask

  // Drop valid when the input side is about to sit still.
  task automatic settle_input();
    if (pending_gap == 0) begin
      in_valid <= 1'b0;
      pending_gap = 1;
    end
  endtask

  // Fill every field with random bits; callers overwrite what they care about.
  function automatic afct_in_t noise_item();
    afct_in_t item;
    item.operation = 2'($urandom_range(0, 3));
    item.slot      = SLOT_W'($urandom_range(0, 7));
    item.value_x   = $urandom;
    item.value_y   = $urandom;
    item.value_z   = $urandom;
    item.value_w   = $urandom;
    item.extent_x  = EXT_W'($urandom);
    item.extent_y  = EXT_W'($urandom);
    item.extent_z  = EXT_W'($urandom);
    return item;
  endfunction

  function automatic afct_in_t plane_load(int slot, int a, int b, int c, int d);
    afct_in_t item;
    item = noise_item();
    item.operation = OP_LOAD_PLANE;
    item.slot      = SLOT_W'(slot);
    item.value_x   = a;
    item.value_y   = b;
    item.value_z   = c;
    item.value_w   = d;
    return item;
  endfunction

  function automatic afct_in_t corner_load(int slot, int x, int y, int z);
    afct_in_t item;
    item = noise_item();
    item.operation = OP_LOAD_CORNER;
    item.slot      = SLOT_W'(slot);
    item.value_x   = x;
    item.value_y   = y;
    item.value_z   = z;
    return item;
  endfunction

  function automatic afct_in_t box_test(int cx, int cy, int cz, int ex, int ey, int ez);
    afct_in_t item;
    item = noise_item();
    item.operation = OP_TEST_BOX;
    item.value_x   = cx;
    item.value_y   = cy;
    item.value_z   = cz;
    item.extent_x  = EXT_W'(ex);
    item.extent_y  = EXT_W'(ey);
    item.extent_z  = EXT_W'(ez);
    return item;
  endfunction

  task automatic note_fault(input string what);
    if (fault_count < 10) $display("mismatch: %s", what);
    fault_count++;
  endtask

  // Result side: stall a random number of cycles after each transaction,
  // check every accepted verdict against the oldest one owed.
  always @(posedge clk) begin
    afct_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cull_expect_q.size() == 0) begin
        note_fault($sformatf("result with no test pending: visible=%0b cause=%0d",
                             out_data.visible, out_data.cull_cause));
      end else begin
        want = cull_expect_q.pop_front();
        if (out_data.visible !== want.visible)
          note_fault($sformatf("visible: expected %0b, got %0b",
                               want.visible, out_data.visible));
        if (out_data.cull_cause !== want.cull_cause)
          note_fault($sformatf("cull_cause: expected %0d, got %0d",
                               want.cull_cause, out_data.cull_cause));
        case (want.cull_cause)
          CAUSE_PLANE: seen_plane++;
          CAUSE_FACE:  seen_face++;
          default:     seen_visible++;
        endcase
      end
      hold_left = calm ? 0 : $urandom_range(0, 3);
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_ready <= (hold_left == 0);
  end

  // Axis-aligned frustum of +-10 units with matching corners; probe inside,
  // outside, and a box whose face just touches a plane and a corner.
  task automatic test_cube_planes();
    int k;
    send_item(plane_load(0,  Q_ONE, 0, 0, 10 * Q_ONE));
    send_item(plane_load(1, -Q_ONE, 0, 0, 10 * Q_ONE));
    send_item(plane_load(2, 0,  Q_ONE, 0, 10 * Q_ONE));
    send_item(plane_load(3, 0, -Q_ONE, 0, 10 * Q_ONE));
    send_item(plane_load(4, 0, 0,  Q_ONE, 10 * Q_ONE));
    send_item(plane_load(5, 0, 0, -Q_ONE, 10 * Q_ONE));
    for (k = 0; k < CORNER_COUNT; k++)
      send_item(corner_load(k, (k & 1) ? 10 * Q_ONE : -10 * Q_ONE,
                               (k & 2) ? 10 * Q_ONE : -10 * Q_ONE,
                               (k & 4) ? 10 * Q_ONE : -10 * Q_ONE));
    send_item(box_test(0, 0, 0, 0, 0, 0));
    send_item(box_test(30 * Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
    // Max x lands exactly on plane 0 and on the corners: zero sum, not beyond.
    send_item(box_test(-11 * Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
  endtask

  // Open the x planes wide so only the corners can reject along x.
  task automatic test_face_rejection();
    send_item(plane_load(0,  Q_ONE, 0, 0, 1000 * Q_ONE));
    send_item(plane_load(1, -Q_ONE, 0, 0, 1000 * Q_ONE));
    send_item(box_test( 30 * Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
    send_item(box_test(-30 * Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
    // Both tests would reject along y; the plane verdict must win.
    send_item(box_test(0, 30 * Q_ONE, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
    // Min x sits on the corners at +10: touching is not beyond.
    send_item(box_test(11 * Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
  endtask

  // Plane slots past the last plane and the reserved operation change nothing.
  task automatic test_ignored_items();
    afct_in_t item;
    send_item(plane_load(PLANE_COUNT,     S32_MIN, S32_MIN, S32_MIN, S32_MIN));
    send_item(plane_load(PLANE_COUNT + 1, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    item = noise_item();
    item.operation = OP_RESERVED;
    send_item(item);
    send_item(box_test(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_field_extremes();
    send_item(box_test(S32_MIN, S32_MAX, 0, EXT_MAX, EXT_MAX, EXT_MAX));
    send_item(box_test(S32_MIN, S32_MIN, S32_MIN, 0, 0, 0));
    send_item(plane_load(0, S32_MIN, S32_MAX, S32_MIN, S32_MAX));
    send_item(corner_load(CORNER_COUNT - 1, S32_MAX, S32_MIN, S32_MAX));
    send_item(box_test(S32_MAX, S32_MAX, S32_MAX, EXT_MAX, EXT_MAX, EXT_MAX));
    send_item(box_test(S32_MAX, S32_MIN, S32_MAX, 0, EXT_MAX, 0));
  endtask

  // Random scenes: a jittered frustum around a random centre, corners at a
  // random fraction of its size, then boxes scattered around it. Some scenes
  // open all planes wide so the face test gets its share.
  task automatic test_random_scenes();
    int mid [AXES];
    int half [AXES];
    int coef [AXES];
    int pos [AXES];
    int ext [AXES];
    longint offset;
    logic loose;
    int spread;
    int axis;
    int sgn;
    int n;
    int i;
    int p;
    int k;
    while (items_sent < ITEM_TARGET) begin
      calm  = ($urandom_range(0, 4) == 0);
      loose = ($urandom_range(0, 2) == 0);
      for (i = 0; i < AXES; i++) begin
        mid[i]  = int'($urandom_range(0, 200)) - 100;
        half[i] = $urandom_range(1, 40);
      end
      for (p = 0; p < PLANE_COUNT; p++) begin
        axis = p / 2;
        sgn  = (p % 2) ? -1 : 1;
        for (i = 0; i < AXES; i++)
          coef[i] = ((i == axis) ? sgn * Q_ONE : 0)
                    + int'($urandom_range(0, Q_ONE / 4)) - Q_ONE / 8;
        offset = longint'(half[axis] - sgn * mid[axis]) * Q_ONE;
        if (loose) offset += 200 * Q_ONE;
        send_item(plane_load(p, coef[0], coef[1], coef[2], int'(offset)));
      end
      if ($urandom_range(0, 3) == 0) send_item(noise_item());
      spread = $urandom_range(2, 4);
      for (k = 0; k < CORNER_COUNT; k++) begin
        for (i = 0; i < AXES; i++)
          pos[i] = (mid[i] + (((k >> i) & 1) ? 1 : -1) * half[i] * spread / 4) * Q_ONE
                   + int'($urandom_range(0, Q_ONE)) - Q_ONE / 2;
        send_item(corner_load(k, pos[0], pos[1], pos[2]));
      end
      n = $urandom_range(10, 22);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(noise_item());
        end else begin
          for (i = 0; i < AXES; i++) begin
            pos[i] = (mid[i] + int'($urandom_range(0, 6 * half[i])) - 3 * half[i]) * Q_ONE
                     + int'($urandom_range(0, Q_ONE - 1));
            ext[i] = $urandom_range(0, 2 * half[i] * Q_ONE);
          end
          send_item(box_test(pos[0], pos[1], pos[2], ext[0], ext[1], ext[2]));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    // Hold reset, then release at an edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every store entry gets loaded by the first test before any box is tested.
    test_cube_planes();
    test_face_rejection();
    test_ignored_items();
    test_field_extremes();
    test_random_scenes();

    // Drain: wait for every owed verdict, then let the block go quiet.
    settle_input();
    while (cull_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d box tests: %0d visible, %0d rejected by a plane, %0d by a face",
             tests_sent, seen_visible, seen_plane, seen_face);
    $display("alongside %0d plane/corner loads and %0d transactions the block drops",
             loads_sent, dropped_sent);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("timeout with %0d verdicts outstanding", cull_expect_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/afct_pkg.sv
rtl/afct_ram.sv
rtl/aabb_frustum_cull_test.sv
sim/tb_aabb_frustum_cull_test.sv
